>>> sv/overlap_track_table_update_top_assert.svh
// Assertion macros for the overlap track table update block.
`ifndef OVERLAP_TRACK_TABLE_UPDATE_TOP_ASSERT_SVH
`define OVERLAP_TRACK_TABLE_UPDATE_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define OTTU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define OTTU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ottu_pkg.sv
// Types and constants shared by the overlap track table update block.
package ottu_pkg;

	localparam int COORD_W = 10;
	localparam int SCORE_W = 16;
	localparam int AREA_W  = 2 * COORD_W;
	localparam int MCNT_W  = 7;
	localparam int SLOT_W  = 6;

	typedef struct packed {
		logic [COORD_W-1:0]        box_x;
		logic [COORD_W-1:0]        box_y;
		logic [COORD_W-1:0]        box_w;
		logic [COORD_W-1:0]        box_h;
		logic signed [SCORE_W-1:0] det_score;
	} det_t;

	typedef struct packed {
		logic              is_face;
		logic [MCNT_W-1:0] match_count;
		logic              created;
		logic              dropped_full;
		logic [SLOT_W-1:0] slot;
	} res_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
	} rect_t;

	typedef struct packed {
		rect_t                     rect;
		logic signed [SCORE_W-1:0] best;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

>>> sv/overlap_track_table_update_top.sv
// Top level of the overlap track table update block: scan pipeline and track memory.
//
// Usage
//  - Request channel: a detection (req) is taken at a rising edge where start is high
//    and busy is low. busy stays high until the result is shown.
//  - Result channel: done is high for exactly one cycle with res valid; the receiver
//    cannot stall, so the result is taken at the edge that ends that cycle.
//  - Scan: every valid entry of the chosen table is read and compared, unless a
//    better-scoring match ends the scan early.
//  - Throughput: one request at a time; busy falls in the done cycle, so the next
//    request can be taken then. The rate is set by the single read port of the track
//    memory, which streams one stored entry per cycle into a three-stage compare.
//  - Reset: both fill counts clear, so both tables start empty; the memory itself is
//    not cleared, since only entries below the fill count are ever read.
//  - Storage: one synchronous memory holds both tables (table select is the top
//    address bit), each word a rectangle and its best score.
module overlap_track_table_update_top #(
	parameter int TRACKS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ottu_pkg::det_t req,
	output logic          done,
	output ottu_pkg::res_t res
);
	import ottu_pkg::*;

`include "overlap_track_table_update_top_assert.svh"

	localparam int CW        = $clog2(TRACKS + 1);
	localparam int IW        = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int MEM_DEPTH = 2 * (2 ** IW);

	// control
	state_t          state_q, state_d;
	logic            tab_q;
	det_t            det_q;
	logic [AREA_W-1:0] adet_q;
	logic [CW-1:0]   face_cnt_q, body_cnt_q, count_sel;
	logic [CW-1:0]   idx_q;
	logic            stop_q;
	logic [CW-1:0]   match_q, slot_q;
	logic            accept, issue, append_we, drop, room;

	// pipeline
	logic            v_s1, v_s2, v_s3;
	logic [IW-1:0]   idx_s1, idx_s2, idx_s3;
	entry_t          word_s1;
	logic [COORD_W-1:0] iw_s2, ih_s2, pw_s2, ph_s2;
	logic signed [SCORE_W-1:0] best_s2, best_s3;
	logic [AREA_W-1:0] inter_s3, aprev_s3;

	// stage logic
	logic [COORD_W:0]   ex1, ey1, px1, py1, ix1, iy1;
	logic [COORD_W-1:0] ix0, iy0;
	logic               ovx, ovy;
	logic [AREA_W:0]    inter2, aprev_x, adet_x;
	logic               hit, better, kill;

	// memory
	entry_t          mem [MEM_DEPTH];
	logic [IW:0]     raddr, waddr;
	entry_t          wdata;
	logic            mem_we;

	assign count_sel = tab_q ? face_cnt_q : body_cnt_q;
	assign room      = count_sel < CW'(TRACKS);
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// leave once nothing is issued and the compare pipeline has drained
				if (!issue && !v_s1 && !v_s2 && !v_s3) state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		issue     = 1'b0;
		append_we = 1'b0;
		drop      = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_SCAN: issue = !stop_q && (idx_q < count_sel);
			ST_FINISH: begin
				append_we = (match_q == '0) && room;
				drop      = (match_q == '0) && !room;
			end
			default: ;
		endcase
	end

	// stage 2 inputs: intersection extents of the detection and the stored rectangle
	always_comb begin
		ex1 = {1'b0, det_q.box_x} + {1'b0, det_q.box_w};
		ey1 = {1'b0, det_q.box_y} + {1'b0, det_q.box_h};
		px1 = {1'b0, word_s1.rect.x} + {1'b0, word_s1.rect.w};
		py1 = {1'b0, word_s1.rect.y} + {1'b0, word_s1.rect.h};
		ix0 = (det_q.box_x > word_s1.rect.x) ? det_q.box_x : word_s1.rect.x;
		iy0 = (det_q.box_y > word_s1.rect.y) ? det_q.box_y : word_s1.rect.y;
		ix1 = (ex1 < px1) ? ex1 : px1;
		iy1 = (ey1 < py1) ? ey1 : py1;
		ovx = ix1 > {1'b0, ix0};
		ovy = iy1 > {1'b0, iy0};
	end

	// stage 3 evaluation: cross-multiplied half-overlap test and score compare
	always_comb begin
		inter2  = {inter_s3, 1'b0};
		aprev_x = {1'b0, aprev_s3};
		adet_x  = {1'b0, adet_q};
		hit     = v_s3 && (aprev_s3 != '0) && (adet_q != '0) &&
			(inter2 >= aprev_x) && (inter2 >= adet_x) &&
			((inter2 > aprev_x) || (inter2 > adet_x));
		better  = det_q.det_score > best_s3;
		kill    = hit && better;
	end

	// memory write: replace a matched entry, or append a new one
	always_comb begin
		mem_we     = hit || append_we;
		raddr      = {tab_q, idx_q[IW-1:0]};
		waddr      = append_we ? {tab_q, count_sel[IW-1:0]} : {tab_q, idx_s3};
		wdata.rect = '{x: det_q.box_x, y: det_q.box_y, w: det_q.box_w, h: det_q.box_h};
		if (append_we || better) begin
			wdata.best = det_q.det_score;
		end else begin
			wdata.best = best_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		word_s1 <= mem[raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			det_q  <= req;
			adet_q <= req.box_w * req.box_h;
		end
		idx_s1   <= idx_q[IW-1:0];
		idx_s2   <= idx_s1;
		idx_s3   <= idx_s2;
		iw_s2    <= (ovx && ovy) ? COORD_W'(ix1 - {1'b0, ix0}) : '0;
		ih_s2    <= (ovx && ovy) ? COORD_W'(iy1 - {1'b0, iy0}) : '0;
		pw_s2    <= word_s1.rect.w;
		ph_s2    <= word_s1.rect.h;
		best_s2  <= word_s1.best;
		inter_s3 <= iw_s2 * ih_s2;
		aprev_s3 <= pw_s2 * ph_s2;
		best_s3  <= best_s2;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tab_q      <= 1'b0;
			face_cnt_q <= '0;
			body_cnt_q <= '0;
			idx_q      <= '0;
			stop_q     <= 1'b0;
			match_q    <= '0;
			slot_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			done       <= 1'b0;
			res        <= '0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == ST_FINISH);
			// drop entries in flight once a better-scoring match ends the scan
			v_s1    <= issue && !kill;
			v_s2    <= v_s1 && !kill;
			v_s3    <= v_s2 && !kill;
			if (accept) begin
				tab_q   <= req.box_w <= req.box_h;
				idx_q   <= '0;
				stop_q  <= 1'b0;
				match_q <= '0;
				slot_q  <= '0;
			end
			if (issue) idx_q <= idx_q + 1'b1;
			if (kill) stop_q <= 1'b1;
			if (hit) begin
				match_q <= match_q + 1'b1;
				slot_q  <= CW'(idx_s3);
			end
			if (append_we) begin
				if (tab_q) face_cnt_q <= face_cnt_q + 1'b1;
				else       body_cnt_q <= body_cnt_q + 1'b1;
			end
			if (state_q == ST_FINISH) begin
				res.is_face      <= tab_q;
				res.match_count  <= MCNT_W'(match_q);
				res.created      <= append_we;
				res.dropped_full <= drop;
				if (append_we) begin
					res.slot <= SLOT_W'(count_sel);
				end else if (drop) begin
					res.slot <= '0;
				end else begin
					res.slot <= SLOT_W'(slot_q);
				end
			end
		end
	end

	`OTTU_ASSERT_NOW(a_excl_outcome, done, !(res.created && res.dropped_full), "created and dropped together")
	`OTTU_ASSERT_NOW(a_face_cnt, 1'b1, face_cnt_q <= CW'(TRACKS), "face count beyond table size")
	`OTTU_ASSERT_NOW(a_body_cnt, 1'b1, body_cnt_q <= CW'(TRACKS), "body count beyond table size")
	`OTTU_ASSERT_NOW(a_write_busy, mem_we, busy, "track memory written while idle")
	`OTTU_ASSERT_NEXT(a_kill_flush, kill, !v_s1 && !v_s2 && !v_s3 && !issue, "scan not flushed after stop")
	`OTTU_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule
